@@ rtl/core/smp_pkg.sv @@
package smp_pkg;

	// fixed field widths
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 16;
	localparam int TOTAL_W   = 17;
	localparam int LEN_W     = 5;
	localparam int PAT_BYTES = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	// match count stops here
	localparam logic [TOTAL_W-1:0] COUNT_SAT = 17'h10000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LO  = 2'd0,
		CFG_PAT_HI  = 2'd1,
		CFG_PAT_LEN = 2'd2
	} cfg_idx_t;

	// one result item
	typedef struct packed {
		logic               found;
		logic               done_res;
		logic [POS_W-1:0]   start_pos;
		logic [POS_W-1:0]   end_pos;
		logic [TOTAL_W-1:0] total_matches;
		logic               overflow;
	} res_t;

endpackage

@@ rtl/core/smp_ifaces.sv @@
interface smp_text_if import smp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              is_last;

	modport source (output valid, output text_byte, output is_last, input ready);
	modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

interface smp_res_if import smp_pkg::*;;
	logic               valid;
	logic               ready;
	logic               found;
	logic               done_res;
	logic [POS_W-1:0]   start_pos;
	logic [POS_W-1:0]   end_pos;
	logic [TOTAL_W-1:0] total_matches;
	logic               overflow;

	modport source (output valid, output found, output done_res, output start_pos,
		output end_pos, output total_matches, output overflow, input ready);
	modport sink (input valid, input found, input done_res, input start_pos,
		input end_pos, input total_matches, input overflow, output ready);
endinterface

@@ rtl/core/smp_compare.sv @@
module smp_compare import smp_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	parameter int WIN_DEPTH   = 15,
	parameter int CNT_W       = 17
) (
	input  logic [BYTE_W-1:0] cur_byte,
	input  logic [BYTE_W-1:0] win [WIN_DEPTH],
	input  logic [CFG_W-1:0]  pat_lo,
	input  logic [CFG_W-1:0]  pat_hi,
	input  logic [LEN_W-1:0]  len_eff,
	input  logic [CNT_W-1:0]  cnt,
	output logic              hit
);

	logic [2*CFG_W-1:0] pat_all;
	logic [BYTE_W-1:0]  cand [MAX_PATTERN];
	logic [3:0]         pat_idx [MAX_PATTERN];
	logic               all_eq;
	logic               enough;

	assign pat_all = {pat_hi, pat_lo};

	// candidate bytes, newest first
	always_comb begin
		cand[0] = cur_byte;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			cand[j] = win[j-1];
		end
	end

	// byte j back from the newest lines up with pattern byte len-1-j
	always_comb begin
		all_eq = 1'b1;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			pat_idx[j] = 4'(len_eff - LEN_W'(j) - LEN_W'(1));
			if (LEN_W'(j) < len_eff) begin
				if (cand[j] != pat_all[{pat_idx[j], 3'b000} +: BYTE_W]) begin
					all_eq = 1'b0;
				end
			end
		end
	end

	// whole match must lie inside this text
	assign enough = ({1'b0, cnt} + (CNT_W+1)'(1)) >= (CNT_W+1)'(len_eff);
	assign hit    = (len_eff != '0) && enough && all_eq;

endmodule

@@ rtl/core/smp_state.sv @@
module smp_state import smp_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [BYTE_W-1:0] cur_byte,
	input  logic              is_last,
	input  logic [CFG_W-1:0]  pat_lo,
	input  logic [CFG_W-1:0]  pat_hi,
	input  logic [LEN_W-1:0]  pat_len,
	output logic              emit,
	output res_t              res
);

	localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int CNT_W     = $clog2(MAX_TEXT + 1);

	logic [BYTE_W-1:0]  win_q [WIN_DEPTH];
	logic [CNT_W-1:0]   cnt_q;
	logic [TOTAL_W-1:0] mcnt_q;
	logic               exc_q;

	logic [LEN_W-1:0]   len_eff;
	logic               cmp_hit;
	logic               over;
	logic               hit;
	logic [TOTAL_W-1:0] mcnt_next;

	// lengths past the window are clamped
	assign len_eff = (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;

	smp_compare #(
		.MAX_PATTERN (MAX_PATTERN),
		.WIN_DEPTH   (WIN_DEPTH),
		.CNT_W       (CNT_W)
	) u_compare (
		.cur_byte (cur_byte),
		.win      (win_q),
		.pat_lo   (pat_lo),
		.pat_hi   (pat_hi),
		.len_eff  (len_eff),
		.cnt      (cnt_q),
		.hit      (cmp_hit)
	);

	// bytes past the length limit never match
	assign over      = cnt_q >= CNT_W'(MAX_TEXT);
	assign hit       = !over && cmp_hit;
	assign mcnt_next = (hit && (mcnt_q < COUNT_SAT)) ? mcnt_q + TOTAL_W'(1) : mcnt_q;
	assign emit      = hit || is_last;

	// result fields for this byte
	always_comb begin
		res.found         = hit;
		res.done_res      = is_last;
		res.start_pos     = hit ? POS_W'(cnt_q) - POS_W'(len_eff) + POS_W'(1) : '0;
		res.end_pos       = hit ? POS_W'(cnt_q) : '0;
		res.total_matches = mcnt_next;
		res.overflow      = exc_q | over;
	end

	// window and counters, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			cnt_q  <= '0;
			mcnt_q <= '0;
			exc_q  <= 1'b0;
		end else if (advance) begin
			if (is_last) begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					win_q[i] <= '0;
				end
				cnt_q  <= '0;
				mcnt_q <= '0;
				exc_q  <= 1'b0;
			end else begin
				win_q[0] <= cur_byte;
				for (int i = 1; i < WIN_DEPTH; i++) begin
					win_q[i] <= win_q[i-1];
				end
				cnt_q  <= over ? cnt_q : cnt_q + CNT_W'(1);
				mcnt_q <= mcnt_next;
				exc_q  <= exc_q | over;
			end
		end
	end

endmodule

@@ rtl/core/substring_match_positions_unit.sv @@
// Streaming substring search over a byte text, overlapping matches included.
// Channel text: one text byte per transfer, is_last marks the final byte.
// Channel result: one transfer for each byte that completes a match or is the
// last byte of a text (found low if nothing ends there); it carries
// start and end positions, the running match count (saturating at 65536) and
// a sticky flag for texts longer than MAX_TEXT bytes. After the last byte the
// window and counters clear for the next text.
// Configuration: cfg_we/cfg_index/cfg_wdata write the pattern (bytes 0-7,
// bytes 8-15) and its length; write only while no text is in flight.
// Timing: a byte taken into the input register is compared combinationally and
// its result is captured in the result register when the input stage advances.
// Throughput: one byte per cycle while the receiver does not stall; the window
// compare against all pattern bytes runs in parallel between the two registers.
// Reset: window, counters and pipeline valids clear; the pattern resets to
// one zero byte. When the receiver stalls, the result register holds and the
// input stage keeps taking bytes that produce no result; a byte that would
// produce one waits in the input register and text ready drops.
module substring_match_positions_unit import smp_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	smp_text_if.sink             text,
	smp_res_if.source            result
);

	logic [CFG_W-1:0]  pat_lo_q;
	logic [CFG_W-1:0]  pat_hi_q;
	logic [LEN_W-1:0]  pat_len_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic              out_valid_q;
	res_t              res_q;

	logic              emit;
	res_t              res_d;
	logic              advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAT_LO:  pat_lo_q  <= cfg_wdata;
				CFG_PAT_HI:  pat_hi_q  <= cfg_wdata;
				CFG_PAT_LEN: pat_len_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage moves on unless its result has nowhere to go
	assign advance    = valid_s1 && (!emit || !out_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.is_last;
		end
	end

	smp_state #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cur_byte (byte_s1),
		.is_last  (last_s1),
		.pat_lo   (pat_lo_q),
		.pat_hi   (pat_hi_q),
		.pat_len  (pat_len_q),
		.emit     (emit),
		.res      (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.found         = res_q.found;
	assign result.done_res      = res_q.done_res;
	assign result.start_pos     = res_q.start_pos;
	assign result.end_pos       = res_q.end_pos;
	assign result.total_matches = res_q.total_matches;
	assign result.overflow      = res_q.overflow;

endmodule

@@ rtl/core/smp_checker.sv @@
module smp_checker import smp_pkg::*; #(
	parameter int MAX_PATTERN = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               found,
	input logic               done_res,
	input logic [POS_W-1:0]   start_pos,
	input logic [POS_W-1:0]   end_pos,
	input logic [TOTAL_W-1:0] total_matches,
	input logic               overflow
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({found, done_res, start_pos, end_pos,
			total_matches, overflow}))
		else $error("result payload changed while stalled");

	// a result without a match only closes a text, with zero positions
	a_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> done_res && start_pos == '0 && end_pos == '0)
		else $error("result without match is malformed");

	// a match spans at most the pattern window and counts at least itself
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && found |-> (POS_W'(end_pos - start_pos) <= POS_W'(MAX_PATTERN - 1))
			&& total_matches != '0 && total_matches <= COUNT_SAT)
		else $error("match span or count out of range");

endmodule

bind substring_match_positions_unit smp_checker #(
	.MAX_PATTERN (MAX_PATTERN)
) u_smp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.found         (result.found),
	.done_res      (result.done_res),
	.start_pos     (result.start_pos),
	.end_pos       (result.end_pos),
	.total_matches (result.total_matches),
	.overflow      (result.overflow)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import smp_pkg::*;

	localparam int MAX_TEXT_LEN = 65536;
	localparam int WIN_BYTES    = 15;
	localparam int MAX_WAIT     = 13;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 1000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	smp_text_if text_ch ();
	smp_res_if  res_ch ();

	substring_match_positions_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.text      (text_ch),
		.result    (res_ch)
	);

	// shadow copy of the pattern registers
	logic [CFG_W-1:0]   pat_lo;
	logic [CFG_W-1:0]   pat_hi;
	logic [LEN_W-1:0]   pat_len;

	// shadow copy of the search state
	logic [BYTE_W-1:0]  text_window [WIN_BYTES];
	logic [TOTAL_W-1:0] text_pos;
	logic [TOTAL_W-1:0] match_total;
	bit                 too_long;

	res_t        pending_results [$];
	int unsigned fail_count;
	int unsigned bytes_sent;
	int unsigned results_checked;
	int unsigned matches_seen;
	int unsigned texts_done;
	int unsigned cycle_count;
	int unsigned rx_hold;
	bit          tx_idle_en;
	bit          rx_idle_en;

	// clock, 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [BYTE_W-1:0] pat_byte(input int unsigned i);
		if (i < 8)
			return pat_lo[8*i +: 8];
		return pat_hi[8*(i-8) +: 8];
	endfunction

	function automatic void clear_search_state();
		for (int i = 0; i < WIN_BYTES; i++)
			text_window[i] = '0;
		text_pos    = '0;
		match_total = '0;
		too_long    = 1'b0;
	endfunction

	// predicted result of one text byte; returns 1 when a transfer is due
	function automatic bit predict_search_result(input logic [BYTE_W-1:0] b, input bit last,
			output res_t r);
		int unsigned len;
		int unsigned k;
		bit          hit;
		len = (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
		hit = 1'b0;
		r   = '0;
		if (text_pos >= MAX_TEXT_LEN) begin
			too_long = 1'b1;
		end else begin
			if (len >= 1 && text_pos >= len - 1 && b == pat_byte(len - 1)) begin
				hit = 1'b1;
				for (k = 1; k < len; k++)
					if (text_window[k-1] != pat_byte(len - 1 - k))
						hit = 1'b0;
			end
			if (hit) begin
				r.start_pos = POS_W'(text_pos - (len - 1));
				r.end_pos   = text_pos[POS_W-1:0];
				if (match_total < COUNT_SAT)
					match_total++;
			end
			text_pos++;
		end
		for (k = WIN_BYTES - 1; k > 0; k--)
			text_window[k] = text_window[k-1];
		text_window[0] = b;
		r.found         = hit;
		r.done_res      = last;
		r.total_matches = match_total;
		r.overflow      = too_long;
		if (last)
			clear_search_state();
		return hit || last;
	endfunction

	task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
			input logic [TOTAL_W-1:0] want);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// result checker, compares each transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("result transfer with no prediction pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("found", res_ch.found, want.found);
				check_field("done_res", res_ch.done_res, want.done_res);
				check_field("start_pos", res_ch.start_pos, want.start_pos);
				check_field("end_pos", res_ch.end_pos, want.end_pos);
				check_field("total_matches", res_ch.total_matches, want.total_matches);
				check_field("overflow", res_ch.overflow, want.overflow);
				if (want.found)
					matches_seen++;
				if (want.done_res)
					texts_done++;
			end
			rx_hold = rx_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
		end
	end

	// result ready with random stalls
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			res_ch.ready <= 1'b0;
			rx_hold--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// one text byte transfer, returns at the accepting edge
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last);
		int unsigned gap;
		res_t        r;
		gap = tx_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
		@(negedge clk);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.is_last   <= last;
		do
			@(posedge clk);
		while (text_ch.ready !== 1'b1);
		bytes_sent++;
		if (predict_search_result(b, last, r))
			pending_results.push_back(r);
	endtask

	// sender holds off until every predicted result has arrived
	task automatic wait_results_drained();
		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_PAT_LO:  pat_lo  = val;
			CFG_PAT_HI:  pat_hi  = val;
			CFG_PAT_LEN: pat_len = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
			input int unsigned len);
		write_reg(CFG_PAT_LO, lo);
		write_reg(CFG_PAT_HI, hi);
		write_reg(CFG_PAT_LEN, CFG_W'(len));
	endtask

	// pattern after reset is a single zero byte; zero bytes match literally
	task automatic test_reset_pattern();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_results_drained();
	endtask

	// longest pattern, match ending on the last byte of the text
	task automatic test_full_length_pattern();
		set_pattern(64'h00FF_A55A_0FF0_FF00, {$urandom, $urandom}, PAT_BYTES);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		for (int i = 0; i < PAT_BYTES; i++)
			send_byte(pat_byte(i), i == PAT_BYTES - 1);
		wait_results_drained();
	endtask

	// overlapping matches, and no match before the pattern fits in the text
	task automatic test_overlap_and_text_start();
		set_pattern(64'hFFFF_FFFF_FFFF_4141, 64'hFFFF_FFFF_FFFF_FFFF, 2);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_byte(8'h41, 1'b1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b1);
		wait_results_drained();
	endtask

	// random patterns and texts built mostly from pattern pieces
	task automatic test_random_texts();
		int unsigned       sent;
		int unsigned       phase;
		int unsigned       len;
		int unsigned       phase_end;
		int unsigned       target;
		int unsigned       n;
		int unsigned       kind;
		logic [BYTE_W-1:0] sym_a;
		logic [BYTE_W-1:0] sym_b;
		logic [CFG_W-1:0]  lo;
		logic [CFG_W-1:0]  hi;
		logic [BYTE_W-1:0] txt [$];
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_results_drained();
			case (phase % 6)
				0:       len = 1;
				1:       len = PAT_BYTES;
				default: len = $urandom_range(1, PAT_BYTES);
			endcase
			case (phase % 5)
				2: begin
					lo = '0;
					hi = '0;
				end
				3: begin
					lo = '1;
					hi = '1;
				end
				4: begin
					// two symbols give self-overlapping patterns
					sym_a = BYTE_W'($urandom);
					sym_b = BYTE_W'($urandom);
					for (int i = 0; i < 8; i++) begin
						lo[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
						hi[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
					end
				end
				default: begin
					lo = {$urandom, $urandom};
					hi = {$urandom, $urandom};
				end
			endcase
			set_pattern(lo, hi, len);
			phase_end = sent + 150;
			while (sent < phase_end && sent < RANDOM_ITEMS) begin
				tx_idle_en = $urandom_range(0, 2) != 0;
				rx_idle_en = $urandom_range(0, 2) != 0;
				target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200)
					: $urandom_range(1, 48);
				txt.delete();
				while (txt.size() < target) begin
					kind = $urandom_range(0, 9);
					if (kind < 4) begin
						for (int i = 0; i < len; i++)
							txt.push_back(pat_byte(i));
					end else if (kind < 6) begin
						// broken copy: a prefix only
						n = $urandom_range(1, len);
						for (int i = 0; i < n; i++)
							txt.push_back(pat_byte(i));
					end else if (kind < 8) begin
						n = $urandom_range(1, 8);
						repeat (n) txt.push_back(pat_byte($urandom_range(0, len - 1)));
					end else begin
						n = $urandom_range(1, 8);
						repeat (n) txt.push_back(BYTE_W'($urandom));
					end
				end
				foreach (txt[i]) begin
					send_byte(txt[i], i == txt.size() - 1);
					if ($urandom_range(0, 99) == 0)
						wait_results_drained();
				end
				sent += txt.size();
			end
			phase++;
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		text_ch.valid     = 1'b0;
		text_ch.text_byte = '0;
		text_ch.is_last   = 1'b0;
		res_ch.ready      = 1'b0;
		rx_hold           = 0;
		tx_idle_en        = 1'b0;
		rx_idle_en        = 1'b0;
		fail_count        = 0;
		bytes_sent        = 0;
		results_checked   = 0;
		matches_seen      = 0;
		texts_done        = 0;
		cycle_count       = 0;
		pat_lo            = '0;
		pat_hi            = '0;
		pat_len           = LEN_W'(1);
		clear_search_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_pattern();
		test_full_length_pattern();
		test_overlap_and_text_start();
		test_random_texts();
		wait_results_drained();

		$display("sent %0d text bytes in %0d texts, checked %0d results with %0d matches",
			bytes_sent, texts_done, results_checked, matches_seen);
		$display("patterns of 1 to %0d bytes with random stalls on both sides, %0d cycles",
			PAT_BYTES, cycle_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
